// ===== src/match_confirmation_filter_core_assert.svh =====
// Assertion macros for the match confirmation filter checker.
`ifndef MATCH_CONFIRMATION_FILTER_CORE_ASSERT_SVH
`define MATCH_CONFIRMATION_FILTER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define MCF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define MCF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/mcf_pkg.sv =====
// Types and constants shared by the match confirmation filter modules.
`timescale 1ns / 1ps
package mcf_pkg;

   localparam int SONG_W   = 16;
   localparam int CONF_W   = 16;
   localparam int OFFSET_W = 32;
   localparam int VOTE_W   = 15;
   localparam int SUM_W    = 20;
   localparam int TICK_W   = 6;
   localparam int EVENT_W  = 3;
   localparam int CSR_W    = 20;
   localparam int CSR_IDX_W = 3;

   localparam logic [EVENT_W-1:0] EV_NO_MATCH  = 3'd0;
   localparam logic [EVENT_W-1:0] EV_NOISE     = 3'd1;
   localparam logic [EVENT_W-1:0] EV_NONE      = 3'd2;
   localparam logic [EVENT_W-1:0] EV_TENTATIVE = 3'd3;
   localparam logic [EVENT_W-1:0] EV_MIX_HOLD  = 3'd4;
   localparam logic [EVENT_W-1:0] EV_CONFIRMED = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_FLOOR      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ACCEPT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_ACCEPT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_SWITCH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_LIMIT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TOLERANCE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EVIDENCE_STREAK  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_EVIDENCE_VOTES   = 3'd7;

   localparam logic [15:0] RST_NOISE_FLOOR      = 16'd6554;
   localparam logic [15:0] RST_FIRST_ACCEPT     = 16'd32768;
   localparam logic [15:0] RST_SWITCH_ACCEPT    = 16'd39322;
   localparam logic [15:0] RST_FORCE_SWITCH     = 16'd55706;
   localparam logic [3:0]  RST_BREAK_LIMIT      = 4'd2;
   localparam logic [19:0] RST_OFFSET_TOLERANCE = 20'd3277;
   localparam logic [5:0]  RST_EVIDENCE_STREAK  = 6'd3;
   localparam logic [19:0] RST_EVIDENCE_VOTES   = 20'd30;

   typedef struct packed {
      logic                       matched;
      logic [SONG_W-1:0]          song_id;
      logic [CONF_W-1:0]          confidence;
      logic signed [OFFSET_W-1:0] offset;
      logic signed [15:0]         aligned_votes;
   } mcf_req_type;

   typedef struct packed {
      logic [EVENT_W-1:0]         event_res;
      logic [SONG_W-1:0]          song_out;
      logic [CONF_W-1:0]          confidence_out;
      logic signed [OFFSET_W-1:0] offset_out;
      logic [TICK_W-1:0]          streak_ticks;
      logic [SUM_W-1:0]           streak_votes;
      logic                       evidence_confirmed;
      logic [SUM_W-1:0]           evidence_total;
      logic                       force_confirmed;
   } mcf_rsp_type;

   typedef struct packed {
      logic [15:0] noise_floor;
      logic [15:0] first_accept;
      logic [15:0] switch_accept;
      logic [15:0] force_switch;
      logic [3:0]  break_limit;
      logic [19:0] offset_tolerance;
      logic [5:0]  evidence_streak;
      logic [19:0] evidence_votes;
   } mcf_cfg_type;

   // A classified match result as handed from the front to the back.
   typedef struct packed {
      logic                       matched;
      logic [SONG_W-1:0]          song_id;
      logic [CONF_W-1:0]          confidence;
      logic signed [OFFSET_W-1:0] offset;
      logic [VOTE_W-1:0]          votes;
      logic                       is_noise;
      logic                       below_first;
      logic                       below_switch;
      logic                       reach_force;
   } mcf_cmd_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] offset;
      logic [VOTE_W-1:0]          votes;
   } mcf_hist_type;

   typedef struct packed {
      logic              done;
      logic [TICK_W-1:0] ticks;
      logic [SUM_W-1:0]  votes;
   } mcf_clu_rsp_type;

endpackage

// ===== src/mcf_front.sv =====
// Front end: accepts match words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module mcf_front
   import mcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mcf_cfg_type cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  mcf_req_type req_word,
   output logic        cmd_valid,
   output mcf_cmd_type cmd,
   input  logic        cmd_pop
);

   mcf_cmd_type queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   mcf_cmd_type cls;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      cls.matched      = req_word.matched;
      cls.song_id      = req_word.song_id;
      cls.confidence   = req_word.confidence;
      cls.offset       = req_word.offset;
      cls.votes        = req_word.aligned_votes[15] ? '0 : req_word.aligned_votes[VOTE_W-1:0];
      cls.is_noise     = req_word.confidence < cfg.noise_floor;
      cls.below_first  = req_word.confidence < cfg.first_accept;
      cls.below_switch = req_word.confidence < cfg.switch_accept;
      cls.reach_force  = req_word.confidence >= cfg.force_switch;
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== src/mcf_cluster.sv =====
// History memory and serial all-pairs offset clustering unit.
`timescale 1ns / 1ps
module mcf_cluster
   import mcf_pkg::*;
#(
   parameter int WINDOW = 8
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [19:0]              tolerance,
   input  logic                     hist_wr_en,
   input  logic [$clog2(WINDOW)-1:0] hist_wr_addr,
   input  mcf_hist_type             hist_wr_data,
   input  logic                     start,
   input  logic [$clog2(WINDOW)-1:0] start_head,
   input  logic [$clog2(WINDOW+1)-1:0] start_fill,
   output mcf_clu_rsp_type          result
);

   localparam int AW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);
   localparam int PW = AW + 1;

   mcf_hist_type hist_mem [WINDOW];

   logic              busy_ff, busy_in;
   logic [AW-1:0]     first_ff, first_in;
   logic [AW-1:0]     ai_ff, ai_in;
   logic [AW-1:0]     bj_ff, bj_in;
   logic [AW-1:0]     i_ff, i_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [CW-1:0]     n_ff, n_in;
   mcf_hist_type      rd_a_ff, rd_b_ff;
   logic              pv_ff, pv_in;
   logic              plast_ff, plast_in;
   logic              pfinal_ff, pfinal_in;
   logic [SUM_W-1:0]  acc_v_ff, acc_v_in;
   logic [TICK_W-1:0] acc_n_ff, acc_n_in;
   logic [SUM_W-1:0]  best_v_ff, best_v_in;
   logic [TICK_W-1:0] best_n_ff, best_n_in;
   logic              done_ff, done_in;

   logic [PW-1:0]     first_sum;
   logic              last_j, last_i;
   logic signed [OFFSET_W:0] diff;
   logic signed [OFFSET_W:0] tol_pos;
   logic signed [OFFSET_W:0] tol_neg;
   logic              hit;
   logic [SUM_W-1:0]  v_next;
   logic [TICK_W-1:0] n_next;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(WINDOW - 1)) ? '0 : p + AW'(1);
   endfunction

   assign result.done  = done_ff;
   assign result.ticks = best_n_ff;
   assign result.votes = best_v_ff;

   always_comb begin
      first_sum = PW'(start_head) + PW'(WINDOW) - PW'(start_fill);
      if (first_sum >= PW'(WINDOW)) begin
         first_sum = first_sum - PW'(WINDOW);
      end
      last_j = (CW'(j_ff) == n_ff - CW'(1));
      last_i = (CW'(i_ff) == n_ff - CW'(1));
      diff    = 33'(rd_b_ff.offset) - 33'(rd_a_ff.offset);
      tol_pos = $signed({13'd0, tolerance});
      tol_neg = -tol_pos;
      hit     = (diff <= tol_pos) && (diff >= tol_neg);
      v_next  = acc_v_ff + (hit ? SUM_W'(rd_b_ff.votes) : '0);
      n_next  = acc_n_ff + TICK_W'(hit);
   end

   // The done flag stays high from the end of a pass until the next start.
   always_comb begin
      busy_in   = busy_ff;
      first_in  = first_ff;
      ai_in     = ai_ff;
      bj_in     = bj_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      pv_in     = 1'b0;
      plast_in  = 1'b0;
      pfinal_in = 1'b0;
      acc_v_in  = acc_v_ff;
      acc_n_in  = acc_n_ff;
      best_v_in = best_v_ff;
      best_n_in = best_n_ff;
      done_in   = done_ff;
      if (start) begin
         busy_in   = 1'b1;
         first_in  = first_sum[AW-1:0];
         ai_in     = first_sum[AW-1:0];
         bj_in     = first_sum[AW-1:0];
         i_in      = '0;
         j_in      = '0;
         n_in      = start_fill;
         acc_v_in  = '0;
         acc_n_in  = '0;
         best_v_in = '0;
         best_n_in = '0;
         done_in   = 1'b0;
      end else if (busy_ff) begin
         pv_in     = 1'b1;
         plast_in  = last_j;
         pfinal_in = last_j && last_i;
         if (last_j) begin
            j_in  = '0;
            bj_in = first_ff;
            i_in  = i_ff + AW'(1);
            ai_in = wrap_inc(ai_ff);
            if (last_i) begin
               busy_in = 1'b0;
            end
         end else begin
            j_in  = j_ff + AW'(1);
            bj_in = wrap_inc(bj_ff);
         end
      end
      if (pv_ff) begin
         acc_v_in = v_next;
         acc_n_in = n_next;
         if (plast_ff) begin
            acc_v_in = '0;
            acc_n_in = '0;
            if (v_next > best_v_ff) begin
               best_v_in = v_next;
               best_n_in = n_next;
            end
         end
         if (pfinal_ff) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pv_ff     <= 1'b0;
         plast_ff  <= 1'b0;
         pfinal_ff <= 1'b0;
         done_ff   <= 1'b0;
         ai_ff     <= '0;
         bj_ff     <= '0;
      end else begin
         busy_ff   <= busy_in;
         pv_ff     <= pv_in;
         plast_ff  <= plast_in;
         pfinal_ff <= pfinal_in;
         done_ff   <= done_in;
         ai_ff     <= ai_in;
         bj_ff     <= bj_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      n_ff      <= n_in;
      acc_v_ff  <= acc_v_in;
      acc_n_ff  <= acc_n_in;
      best_v_ff <= best_v_in;
      best_n_ff <= best_n_in;
   end

   always_ff @(posedge clock) begin
      if (hist_wr_en) begin
         hist_mem[hist_wr_addr] <= hist_wr_data;
      end
      rd_a_ff <= hist_mem[ai_ff];
      rd_b_ff <= hist_mem[bj_ff];
   end

endmodule

// ===== src/mcf_back.sv =====
// Back end: candidate and confirmation state, history updates and the result register.
`timescale 1ns / 1ps
module mcf_back
   import mcf_pkg::*;
#(
   parameter int WINDOW     = 8,
   parameter int HOLD_TICKS = 8
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  mcf_cfg_type                 cfg,
   input  logic                        cmd_valid,
   input  mcf_cmd_type                 cmd,
   output logic                        cmd_pop,
   output logic                        hist_wr_en,
   output logic [$clog2(WINDOW)-1:0]   hist_wr_addr,
   output mcf_hist_type                hist_wr_data,
   output logic                        clu_start,
   output logic [$clog2(WINDOW)-1:0]   clu_head,
   output logic [$clog2(WINDOW+1)-1:0] clu_fill,
   input  mcf_clu_rsp_type             clu_result,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mcf_rsp_type                 rsp_word
);

   localparam int AW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_CLUSTER = 1'b1;

   typedef struct packed {
      logic              ten_v;
      logic [SONG_W-1:0] ten_song;
      logic [7:0]        hold;
      logic              brk_v;
      logic [SONG_W-1:0] brk_song;
      logic [3:0]        brk_cnt;
      logic [CW-1:0]     fill;
      logic [AW-1:0]     head;
   } cand_type;

   logic              state_ff, state_in;
   logic              cur_v_ff, cur_v_in;
   logic [SONG_W-1:0] cur_song_ff, cur_song_in;
   cand_type          cand_ff, cand_in;
   mcf_cmd_type       item_ff, item_in;
   mcf_rsp_type       rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              out_free;
   logic              is_cur;
   logic              below_gate;
   logic              feed;
   logic              confirm;
   cand_type          c;
   mcf_rsp_type       r;

   function automatic cand_type drop(input cand_type x);
      cand_type y;
      y = x;
      y.ten_v    = 1'b0;
      y.ten_song = '0;
      y.hold     = '0;
      y.brk_v    = 1'b0;
      y.brk_song = '0;
      y.brk_cnt  = '0;
      y.fill     = '0;
      y.head     = '0;
      return y;
   endfunction

   function automatic cand_type age(input cand_type x);
      cand_type y;
      y = x;
      if (x.ten_v) begin
         if (x.hold <= 8'd1) begin
            y = drop(x);
         end else begin
            y.hold = x.hold - 8'd1;
         end
      end
      return y;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_cur    = cur_v_ff && (cmd.song_id == cur_song_ff);
   assign below_gate = cur_v_ff ? cmd.below_switch : cmd.below_first;
   assign confirm   = (clu_result.ticks >= cfg.evidence_streak)
                      && (clu_result.votes >= cfg.evidence_votes);

   always_comb begin
      state_in     = state_ff;
      cur_v_in     = cur_v_ff;
      cur_song_in  = cur_song_ff;
      cand_in      = cand_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_pop      = 1'b0;
      hist_wr_en   = 1'b0;
      hist_wr_addr = cand_ff.head;
      hist_wr_data.offset = cmd.offset;
      hist_wr_data.votes  = cmd.votes;
      clu_start    = 1'b0;
      clu_head     = cand_ff.head;
      clu_fill     = cand_ff.fill;
      feed         = 1'b0;
      c            = cand_ff;
      r            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop          = 1'b1;
               r.song_out       = cmd.song_id;
               r.confidence_out = cmd.confidence;
               r.offset_out     = cmd.offset;
               if (!cmd.matched) begin
                  c = age(c);
                  r.event_res = EV_NO_MATCH;
               end else if (cmd.is_noise) begin
                  c = age(c);
                  r.event_res = EV_NOISE;
               end else if (below_gate) begin
                  r.event_res = EV_NONE;
                  feed = 1'b1;
                  if (is_cur) begin
                     c = age(c);
                     feed = 1'b0;
                  end else if (!c.ten_v) begin
                     c.ten_v    = 1'b1;
                     c.ten_song = cmd.song_id;
                     c.brk_v    = 1'b0;
                     c.brk_song = '0;
                     c.brk_cnt  = '0;
                  end else if (cmd.song_id == c.ten_song) begin
                     c.brk_v    = 1'b0;
                     c.brk_song = '0;
                     c.brk_cnt  = '0;
                  end else begin
                     if (c.brk_v && (cmd.song_id == c.brk_song)) begin
                        if (c.brk_cnt != 4'hF) begin
                           c.brk_cnt = c.brk_cnt + 4'd1;
                        end
                     end else begin
                        c.brk_v    = 1'b1;
                        c.brk_song = cmd.song_id;
                        c.brk_cnt  = 4'd1;
                     end
                     if (c.brk_cnt >= cfg.break_limit) begin
                        c = drop(c);
                        c.ten_v    = 1'b1;
                        c.ten_song = cmd.song_id;
                     end else begin
                        c = age(c);
                        feed = 1'b0;
                     end
                  end
                  if (feed) begin
                     c.hold       = 8'(HOLD_TICKS);
                     hist_wr_en   = 1'b1;
                     hist_wr_addr = c.head;
                     c.head = (c.head == AW'(WINDOW - 1)) ? '0 : c.head + AW'(1);
                     if (c.fill < CW'(WINDOW)) begin
                        c.fill = c.fill + CW'(1);
                     end
                     clu_start = 1'b1;
                     clu_head  = c.head;
                     clu_fill  = c.fill;
                     item_in   = cmd;
                     state_in  = ST_CLUSTER;
                  end
               end else if (is_cur) begin
                  c = age(c);
                  r.event_res = EV_NONE;
               end else begin
                  r.force_confirmed = cmd.reach_force;
                  r.event_res       = EV_CONFIRMED;
                  cur_v_in    = 1'b1;
                  cur_song_in = cmd.song_id;
                  c = drop(c);
               end
               cand_in = c;
               if (!feed) begin
                  rsp_in       = r;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_CLUSTER: begin
            if (clu_result.done && out_free) begin
               r.song_out       = item_ff.song_id;
               r.confidence_out = item_ff.confidence;
               r.offset_out     = item_ff.offset;
               if (confirm) begin
                  r.event_res          = EV_CONFIRMED;
                  r.evidence_confirmed = 1'b1;
                  r.evidence_total     = clu_result.votes;
                  cur_v_in    = 1'b1;
                  cur_song_in = item_ff.song_id;
                  cand_in     = drop(cand_ff);
               end else begin
                  r.event_res    = cur_v_ff ? EV_MIX_HOLD : EV_TENTATIVE;
                  r.streak_ticks = clu_result.ticks;
                  r.streak_votes = clu_result.votes;
               end
               rsp_in       = r;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_v_ff     <= 1'b0;
         cur_song_ff  <= '0;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_v_ff     <= cur_v_in;
         cur_song_ff  <= cur_song_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== src/match_confirmation_filter_core.sv =====
// Top level of the match confirmation filter: register file, front end, back end and clustering.
`timescale 1ns / 1ps
// Takes one fingerprint match word at a time and returns one result word for it. A word that
// does not add to the clustered evidence has its result offered from the result register once
// the back end takes it from the queue; a word that enters the offset history waits for the
// serial clustering unit, which compares one pair of history entries per cycle over all
// fill * fill pairs of the history. Stalls on the result side hold a finished result in the
// result register. A two-word queue sits between the front and back ends, and the queue lets
// the next word be accepted while a finished result is still held. Registers may be written
// only while no word is in flight.
module match_confirmation_filter_core
   import mcf_pkg::*;
#(
   parameter int WINDOW     = 8,
   parameter int HOLD_TICKS = 8
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mcf_req_type          req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mcf_rsp_type          rsp_word,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);

   mcf_cfg_type     cfg_ff, cfg_in;
   logic            cmd_valid;
   mcf_cmd_type     cmd;
   logic            cmd_pop;
   logic            hist_wr_en;
   logic [AW-1:0]   hist_wr_addr;
   mcf_hist_type    hist_wr_data;
   logic            clu_start;
   logic [AW-1:0]   clu_head;
   logic [CW-1:0]   clu_fill;
   mcf_clu_rsp_type clu_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_NOISE_FLOOR:      cfg_in.noise_floor      = csr_wdata[15:0];
            CSR_FIRST_ACCEPT:     cfg_in.first_accept     = csr_wdata[15:0];
            CSR_SWITCH_ACCEPT:    cfg_in.switch_accept    = csr_wdata[15:0];
            CSR_FORCE_SWITCH:     cfg_in.force_switch     = csr_wdata[15:0];
            CSR_BREAK_LIMIT:      cfg_in.break_limit      = csr_wdata[3:0];
            CSR_OFFSET_TOLERANCE: cfg_in.offset_tolerance = csr_wdata[19:0];
            CSR_EVIDENCE_STREAK:  cfg_in.evidence_streak  = csr_wdata[5:0];
            CSR_EVIDENCE_VOTES:   cfg_in.evidence_votes   = csr_wdata[19:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_floor      <= RST_NOISE_FLOOR;
         cfg_ff.first_accept     <= RST_FIRST_ACCEPT;
         cfg_ff.switch_accept    <= RST_SWITCH_ACCEPT;
         cfg_ff.force_switch     <= RST_FORCE_SWITCH;
         cfg_ff.break_limit      <= RST_BREAK_LIMIT;
         cfg_ff.offset_tolerance <= RST_OFFSET_TOLERANCE;
         cfg_ff.evidence_streak  <= RST_EVIDENCE_STREAK;
         cfg_ff.evidence_votes   <= RST_EVIDENCE_VOTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   mcf_cluster #(
      .WINDOW (WINDOW)
   ) u_cluster (
      .clock        (clock),
      .reset        (reset),
      .tolerance    (cfg_ff.offset_tolerance),
      .hist_wr_en   (hist_wr_en),
      .hist_wr_addr (hist_wr_addr),
      .hist_wr_data (hist_wr_data),
      .start        (clu_start),
      .start_head   (clu_head),
      .start_fill   (clu_fill),
      .result       (clu_result)
   );

   mcf_back #(
      .WINDOW     (WINDOW),
      .HOLD_TICKS (HOLD_TICKS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .hist_wr_en   (hist_wr_en),
      .hist_wr_addr (hist_wr_addr),
      .hist_wr_data (hist_wr_data),
      .clu_start    (clu_start),
      .clu_head     (clu_head),
      .clu_fill     (clu_fill),
      .clu_result   (clu_result),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

endmodule

// ===== src/mcf_checker.sv =====
// Port-level checker for the match confirmation filter and its bind to the top level.
`timescale 1ns / 1ps
`include "match_confirmation_filter_core_assert.svh"
module mcf_checker
   import mcf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input mcf_rsp_type rsp_word
);

   logic streak_event;
   logic streak_clear;
   logic any_confirm_flag;
   logic flags_consistent;

   assign streak_event     = (rsp_word.event_res == EV_TENTATIVE)
                             || (rsp_word.event_res == EV_MIX_HOLD);
   assign streak_clear     = (rsp_word.streak_ticks == '0) && (rsp_word.streak_votes == '0);
   assign any_confirm_flag = rsp_word.evidence_confirmed || rsp_word.force_confirmed
                             || (rsp_word.evidence_total != '0);
   assign flags_consistent = (rsp_word.event_res == EV_CONFIRMED)
                             && !(rsp_word.evidence_confirmed && rsp_word.force_confirmed)
                             && (rsp_word.evidence_confirmed || (rsp_word.evidence_total == '0));

   // A held result word must not change or vanish while the receiver stalls.
   `MCF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "result word changed while stalled")

   // Streak figures are only reported for tentative and mix hold events.
   `MCF_ASSERT(a_streak_zero, rsp_valid && !streak_event |-> streak_clear, "streak figures set outside a streak event")

   // Confirmation flags appear only on confirmed events, never both, and the total only with evidence.
   `MCF_ASSERT(a_confirm_flags, rsp_valid && any_confirm_flag |-> flags_consistent, "inconsistent confirmation flags")

   // No result word is offered in the cycle after reset.
   `MCF_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result offered straight after reset")

   // The input queue is empty, and so open, in the cycle after reset.
   `MCF_ASSERT_ALWAYS(a_reset_open, reset |=> !req_stall, "input stalled straight after reset")

endmodule

bind match_confirmation_filter_core mcf_checker u_mcf_checker (.*);

// ===== bench/match_confirmation_filter_core_tb.sv =====
// Self-checking testbench for the match confirmation filter core: a directed table, then random words.
`timescale 1ns / 1ps
module match_confirmation_filter_core_tb;
   import mcf_pkg::*;

   localparam int WINDOW          = 8;
   localparam int HOLD_TICKS      = 8;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 140;
   localparam int SETTLE_CYCLES   = 80;
   localparam int PRESSURE_HOLD   = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int EXPECT_DEPTH    = 64;
   localparam int MAX_ROWS        = 64;

   typedef enum {SET_TYPICAL, SET_FLOOR, SET_CEILING, SET_RAW} setting_kind_type;

   typedef struct {
      mcf_req_type word;
      bit          typed;
      mcf_rsp_type want;
   } directed_row_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   mcf_req_type          req_word     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   mcf_rsp_type          rsp_word;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CSR_W-1:0]     csr_wdata    = '0;

   // Predicted filter state and register copy.
   mcf_cfg_type              model_cfg;
   logic                     held_valid  = 1'b0;
   logic [SONG_W-1:0]        held_song   = '0;
   logic                     cand_valid  = 1'b0;
   logic [SONG_W-1:0]        cand_song   = '0;
   logic [7:0]               cand_hold   = '0;
   logic                     rival_valid = 1'b0;
   logic [SONG_W-1:0]        rival_song  = '0;
   logic [3:0]               rival_count = '0;
   logic signed [OFFSET_W-1:0] hist_offset [WINDOW];
   logic [VOTE_W-1:0]        hist_votes [WINDOW];
   int unsigned              hist_fill = 0;
   int unsigned              hist_head = 0;

   // Expected result words waiting for the block, oldest at expect_rd.
   mcf_rsp_type      expect_ring [EXPECT_DEPTH];
   int unsigned      expect_wr = 0;
   int unsigned      expect_rd = 0;
   directed_row_type directed_rows [MAX_ROWS];
   int               row_count = 0;

   logic [SONG_W-1:0]          song_pool [3];
   logic signed [OFFSET_W-1:0] offset_pool [3];

   bit calm_phase    = 1'b0;
   bit pressure_due  = 1'b0;
   int mismatch_count = 0;
   int idle_cycles    = 0;
   int words_checked  = 0;
   int settings_used  = 1;
   int seen_confirm   = 0;
   int seen_evidence  = 0;
   int seen_forced    = 0;
   int seen_tentative = 0;
   int seen_mix_hold  = 0;

   always #1 clock = ~clock;

   match_confirmation_filter_core #(
      .WINDOW     (WINDOW),
      .HOLD_TICKS (HOLD_TICKS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   function automatic void clear_candidate();
      cand_valid  = 1'b0;
      cand_song   = '0;
      cand_hold   = '0;
      rival_valid = 1'b0;
      rival_song  = '0;
      rival_count = '0;
      hist_fill   = 0;
      hist_head   = 0;
   endfunction

   function automatic void decay_candidate();
      if (!cand_valid) return;
      if (cand_hold <= 8'd1) clear_candidate();
      else cand_hold = cand_hold - 8'd1;
   endfunction

   function automatic void cluster_history(input mcf_req_type w, output logic [TICK_W-1:0] ticks,
                                           output logic [SUM_W-1:0] best_sum);
      int unsigned first_slot, a, b, n, v;
      longint d;
      cand_hold = 8'(HOLD_TICKS);
      hist_offset[hist_head] = w.offset;
      hist_votes[hist_head] = (w.aligned_votes < 0) ? '0 : w.aligned_votes[VOTE_W-1:0];
      hist_head = (hist_head + 1) % WINDOW;
      if (hist_fill < WINDOW) hist_fill++;
      first_slot = (hist_head + WINDOW - hist_fill) % WINDOW;
      ticks = '0;
      best_sum = '0;
      for (int i = 0; i < hist_fill; i++) begin
         a = (first_slot + i) % WINDOW;
         n = 0;
         v = 0;
         for (int j = 0; j < hist_fill; j++) begin
            b = (first_slot + j) % WINDOW;
            d = longint'(hist_offset[b]) - longint'(hist_offset[a]);
            if (d < 0) d = -d;
            if (d <= longint'(model_cfg.offset_tolerance)) begin
               v += hist_votes[b];
               n++;
            end
         end
         if (v > best_sum) begin
            best_sum = SUM_W'(v);
            ticks = TICK_W'(n);
         end
      end
   endfunction

   function automatic mcf_rsp_type predict_result(input mcf_req_type w);
      mcf_rsp_type       r;
      logic              is_held, feed;
      logic [CONF_W-1:0] gate;
      logic [TICK_W-1:0] ticks;
      logic [SUM_W-1:0]  best_sum;
      r = '0;
      r.song_out = w.song_id;
      r.confidence_out = w.confidence;
      r.offset_out = w.offset;
      is_held = held_valid && (w.song_id == held_song);
      gate = held_valid ? model_cfg.switch_accept : model_cfg.first_accept;
      if (!w.matched) begin
         decay_candidate();
         r.event_res = EV_NO_MATCH;
      end else if (w.confidence < model_cfg.noise_floor) begin
         decay_candidate();
         r.event_res = EV_NOISE;
      end else if (w.confidence < gate) begin
         feed = 1'b1;
         r.event_res = EV_NONE;
         if (is_held) begin
            decay_candidate();
            feed = 1'b0;
         end else if (!cand_valid || w.song_id == cand_song) begin
            cand_valid  = 1'b1;
            cand_song   = w.song_id;
            rival_valid = 1'b0;
            rival_song  = '0;
            rival_count = '0;
         end else begin
            if (rival_valid && w.song_id == rival_song) begin
               if (rival_count < 4'd15) rival_count = rival_count + 4'd1;
            end else begin
               rival_valid = 1'b1;
               rival_song  = w.song_id;
               rival_count = 4'd1;
            end
            if (rival_count >= model_cfg.break_limit) begin
               clear_candidate();
               cand_valid = 1'b1;
               cand_song  = w.song_id;
               cand_hold  = 8'(HOLD_TICKS);
            end else begin
               decay_candidate();
               feed = 1'b0;
            end
         end
         if (feed) begin
            cluster_history(w, ticks, best_sum);
            if (ticks >= model_cfg.evidence_streak && best_sum >= model_cfg.evidence_votes) begin
               r.evidence_total = best_sum;
               r.evidence_confirmed = 1'b1;
               r.event_res = EV_CONFIRMED;
               held_valid = 1'b1;
               held_song = w.song_id;
               clear_candidate();
            end else begin
               r.streak_ticks = ticks;
               r.streak_votes = best_sum;
               r.event_res = held_valid ? EV_MIX_HOLD : EV_TENTATIVE;
            end
         end
      end else if (is_held) begin
         decay_candidate();
         r.event_res = EV_NONE;
      end else begin
         r.force_confirmed = (w.confidence >= model_cfg.force_switch);
         r.event_res = EV_CONFIRMED;
         held_valid = 1'b1;
         held_song = w.song_id;
         clear_candidate();
      end
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic signed [63:0] want_v,
                                         input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   function automatic void check_response(input mcf_rsp_type got);
      mcf_rsp_type want;
      if (expect_wr == expect_rd) begin
         $error("Result word arrived with no expectation waiting");
         mismatch_count++;
         return;
      end
      want = expect_ring[expect_rd % EXPECT_DEPTH];
      expect_rd++;
      words_checked++;
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("song_out", want.song_out, got.song_out);
      compare_field("confidence_out", want.confidence_out, got.confidence_out);
      compare_field("offset_out", want.offset_out, got.offset_out);
      compare_field("streak_ticks", want.streak_ticks, got.streak_ticks);
      compare_field("streak_votes", want.streak_votes, got.streak_votes);
      compare_field("evidence_confirmed", want.evidence_confirmed, got.evidence_confirmed);
      compare_field("evidence_total", want.evidence_total, got.evidence_total);
      compare_field("force_confirmed", want.force_confirmed, got.force_confirmed);
      if (got.event_res == EV_CONFIRMED) seen_confirm++;
      if (got.event_res == EV_TENTATIVE) seen_tentative++;
      if (got.event_res == EV_MIX_HOLD) seen_mix_hold++;
      if (got.evidence_confirmed) seen_evidence++;
      if (got.force_confirmed) seen_forced++;
   endfunction

   function automatic void add_row(input bit m, input logic [15:0] s, input logic [15:0] c,
                                   input logic [31:0] o, input logic [15:0] v, input bit typed,
                                   input logic [EVENT_W-1:0] ev, input bit forced);
      directed_row_type row;
      row.word.matched = m;
      row.word.song_id = s;
      row.word.confidence = c;
      row.word.offset = o;
      row.word.aligned_votes = v;
      row.typed = typed;
      row.want = '0;
      row.want.event_res = ev;
      row.want.song_out = s;
      row.want.confidence_out = c;
      row.want.offset_out = o;
      row.want.force_confirmed = forced;
      directed_rows[row_count] = row;
      row_count++;
   endfunction

   function automatic mcf_req_type make_random_word();
      mcf_req_type       w;
      int unsigned       pick, k, t;
      int                jitter;
      logic [CONF_W-1:0] gate;
      pick = $urandom_range(0, 99);
      w.matched = 1'($urandom);
      w.song_id = 16'($urandom);
      w.confidence = 16'($urandom);
      w.offset = $urandom;
      w.aligned_votes = 16'($urandom);
      if (pick < 78) begin
         k = $urandom_range(0, 2);
         gate = held_valid ? model_cfg.switch_accept : model_cfg.first_accept;
         t = (model_cfg.offset_tolerance > 65535) ? 65535 : model_cfg.offset_tolerance;
         jitter = int'($urandom_range(0, 2 * t)) - int'(t);
         w.matched = 1'b1;
         w.song_id = song_pool[k];
         if (pick < 64 && gate > model_cfg.noise_floor)
            w.confidence = 16'($urandom_range(model_cfg.noise_floor, gate - 16'd1));
         else
            w.confidence = 16'($urandom_range(model_cfg.noise_floor, 65535));
         if ($urandom_range(0, 4) != 0) w.offset = offset_pool[k] + jitter;
         if ($urandom_range(0, 7) != 0) w.aligned_votes = 16'($urandom_range(0, 40));
      end
      return w;
   endfunction

   task automatic offer_word(input mcf_req_type w, input bit typed, input mcf_rsp_type want);
      int gap;
      mcf_rsp_type predicted;
      gap = calm_phase ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_result(w);
      expect_ring[expect_wr % EXPECT_DEPTH] = typed ? want : predicted;
      expect_wr++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expect_wr != expect_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input setting_kind_type kind);
      logic [CSR_W-1:0]     value [8];
      logic [CSR_IDX_W-1:0] idx;
      case (kind)
         SET_TYPICAL: begin
            value[CSR_NOISE_FLOOR]      = $urandom_range(0, 16000);
            value[CSR_FIRST_ACCEPT]     = $urandom_range(value[CSR_NOISE_FLOOR], 50000);
            value[CSR_SWITCH_ACCEPT]    = $urandom_range(value[CSR_FIRST_ACCEPT], 62000);
            value[CSR_FORCE_SWITCH]     = $urandom_range(value[CSR_FIRST_ACCEPT], 65535);
            value[CSR_BREAK_LIMIT]      = $urandom_range(1, 4);
            value[CSR_OFFSET_TOLERANCE] = $urandom_range(0, 20000);
            value[CSR_EVIDENCE_STREAK]  = $urandom_range(1, 6);
            value[CSR_EVIDENCE_VOTES]   = $urandom_range(0, 200);
         end
         SET_FLOOR: begin
            foreach (value[i]) value[i] = '0;
         end
         SET_CEILING: begin
            value[CSR_NOISE_FLOOR]      = 20'hFFFF;
            value[CSR_FIRST_ACCEPT]     = 20'hFFFF;
            value[CSR_SWITCH_ACCEPT]    = 20'hFFFF;
            value[CSR_FORCE_SWITCH]     = 20'hFFFF;
            value[CSR_BREAK_LIMIT]      = 20'hF;
            value[CSR_OFFSET_TOLERANCE] = 20'hFFFFF;
            value[CSR_EVIDENCE_STREAK]  = 20'h3F;
            value[CSR_EVIDENCE_VOTES]   = 20'hFFFFF;
         end
         default: begin
            foreach (value[i]) value[i] = 20'($urandom);
         end
      endcase
      for (int i = 0; i < 8; i++) begin
         idx = CSR_IDX_W'(i);
         csr_write_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value[i];
         @(posedge clock);
         case (idx)
            CSR_NOISE_FLOOR:      model_cfg.noise_floor      = value[i][15:0];
            CSR_FIRST_ACCEPT:     model_cfg.first_accept     = value[i][15:0];
            CSR_SWITCH_ACCEPT:    model_cfg.switch_accept    = value[i][15:0];
            CSR_FORCE_SWITCH:     model_cfg.force_switch     = value[i][15:0];
            CSR_BREAK_LIMIT:      model_cfg.break_limit      = value[i][3:0];
            CSR_OFFSET_TOLERANCE: model_cfg.offset_tolerance = value[i][19:0];
            CSR_EVIDENCE_STREAK:  model_cfg.evidence_streak  = value[i][5:0];
            CSR_EVIDENCE_VOTES:   model_cfg.evidence_votes   = value[i][19:0];
            default: ;
         endcase
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_response(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : result_pacing
      int hold;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         hold = calm_phase ? 0 : $urandom_range(0, 10);
         if (pressure_due) begin
            hold = PRESSURE_HOLD;
            pressure_due = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      setting_kind_type plan [PHASES];
      mcf_rsp_type      unused;
      plan = '{SET_TYPICAL, SET_FLOOR, SET_TYPICAL, SET_CEILING,
               SET_TYPICAL, SET_RAW, SET_TYPICAL, SET_RAW};
      unused = '0;
      model_cfg.noise_floor      = RST_NOISE_FLOOR;
      model_cfg.first_accept     = RST_FIRST_ACCEPT;
      model_cfg.switch_accept    = RST_SWITCH_ACCEPT;
      model_cfg.force_switch     = RST_FORCE_SWITCH;
      model_cfg.break_limit      = RST_BREAK_LIMIT;
      model_cfg.offset_tolerance = RST_OFFSET_TOLERANCE;
      model_cfg.evidence_streak  = RST_EVIDENCE_STREAK;
      model_cfg.evidence_votes   = RST_EVIDENCE_VOTES;
      foreach (hist_offset[i]) begin
         hist_offset[i] = '0;
         hist_votes[i] = '0;
      end

      add_row(0, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 16'h7FFF, 1, EV_NO_MATCH, 0);
      add_row(1, 16'h0000, 16'h0000, 32'h8000_0000, 16'h8000, 1, EV_NOISE, 0);
      add_row(1, 16'h1234, RST_NOISE_FLOOR - 16'd1, 32'd0, 16'd10, 1, EV_NOISE, 0);
      add_row(1, 16'd5, RST_NOISE_FLOOR, 32'd0, 16'd10, 0, EV_NONE, 0);
      add_row(1, 16'd5, 16'd20000, 32'd100, 16'd10, 0, EV_NONE, 0);
      add_row(1, 16'd5, 16'd20000, 32'd200, 16'd10, 0, EV_NONE, 0);
      add_row(1, 16'd5, 16'd20000, 32'd0, 16'd10, 0, EV_NONE, 0);
      add_row(1, 16'd5, 16'hFFFF, 32'd0, 16'd10, 0, EV_NONE, 0);
      add_row(1, 16'd9, 16'd30000, 32'd0, 16'hFFFB, 0, EV_NONE, 0);
      add_row(1, 16'd7, 16'd30000, 32'd0, 16'd50, 0, EV_NONE, 0);
      add_row(1, 16'd7, 16'd30000, 32'd0, 16'd50, 0, EV_NONE, 0);
      add_row(1, 16'd7, 16'd30000, 32'h1000_0000, 16'd50, 0, EV_NONE, 0);
      repeat (HOLD_TICKS) add_row(0, 16'd7, 16'd30000, 32'd0, 16'd50, 1, EV_NO_MATCH, 0);
      add_row(1, 16'd7, 16'd30000, 32'd0, 16'd50, 0, EV_NONE, 0);
      add_row(1, 16'd3, RST_SWITCH_ACCEPT, 32'd0, 16'd0, 1, EV_CONFIRMED, 0);
      add_row(1, 16'd4, RST_FORCE_SWITCH, 32'hFFFF_FFFF, 16'd0, 1, EV_CONFIRMED, 1);
      add_row(1, 16'd4, 16'hFFFF, 32'd0, 16'd0, 1, EV_NONE, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < row_count; i++)
         offer_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         calm_phase = (p == 4 || p == 6);
         write_settings(plan[p]);
         foreach (song_pool[k]) begin
            song_pool[k] = 16'($urandom);
            offset_pool[k] = $urandom;
         end
         if (p == 2) pressure_due = 1'b1;
         repeat (WORDS_PER_PHASE) offer_word(make_random_word(), 1'b0, unused);
      end
      drain_results();

      $display("Checked %0d result words (%0d from the directed table) over %0d register settings.",
               words_checked, row_count, settings_used);
      $display("Seen %0d confirmations (%0d by evidence, %0d forced), %0d tentative, %0d mix-hold.",
               seen_confirm, seen_evidence, seen_forced, seen_tentative, seen_mix_hold);
      if (mismatch_count == 0 && expect_wr == expect_rd) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/mcf_pkg.sv
src/mcf_front.sv
src/mcf_cluster.sv
src/mcf_back.sv
src/match_confirmation_filter_core.sv
src/mcf_checker.sv
bench/match_confirmation_filter_core_tb.sv
